/* sv/b32dec_pkg.sv */
package b32dec_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned GROUP_BITS  = 40;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

  typedef struct packed {
    logic [GROUP_BITS-1:0] bytes;
    logic [2:0]            count;
    logic [1:0]            status;
    logic                  msg_end;
  } job_t;

  // Bit 5 set: valid symbol, bits 4:0 its value.
  function automatic logic [5:0] map_symbol(logic [7:0] c);
    logic [7:0] u;
    logic [5:0] r;
    u = (c >= 8'h61 && c <= 8'h7a) ? (c - 8'h20) : c;
    r = 6'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 1'b0, c[3:0]};
    end else if (u >= 8'h41 && u <= 8'h48) begin
      r = {1'b1, 5'(u - 8'h37)};
    end else begin
      case (u)
        8'h49, 8'h4c: r = {1'b1, 5'd1};
        8'h4f, 8'h51: r = {1'b1, 5'd0};
        8'h4a:        r = {1'b1, 5'd18};
        8'h4b:        r = {1'b1, 5'd19};
        8'h4d:        r = {1'b1, 5'd20};
        8'h4e:        r = {1'b1, 5'd21};
        8'h50:        r = {1'b1, 5'd22};
        8'h52:        r = {1'b1, 5'd23};
        8'h53:        r = {1'b1, 5'd24};
        8'h54:        r = {1'b1, 5'd25};
        8'h55, 8'h56: r = {1'b1, 5'd26};
        8'h57:        r = {1'b1, 5'd27};
        8'h58:        r = {1'b1, 5'd28};
        8'h59:        r = {1'b1, 5'd29};
        8'h5a:        r = {1'b1, 5'd30};
        8'h5f:        r = {1'b1, 5'd31};
        default:      r = 6'd0;
      endcase
    end
    return r;
  endfunction

endpackage

/* sv/b32dec_front.sv */
module b32dec_front import b32dec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] symbol_i,
  input  logic       msg_end_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic [GROUP_BITS-1:0] group_bits_q, group_bits_d;
  logic [2:0]            held_q, held_d;
  logic                  invalid_q, invalid_d;
  logic                  discard_q, discard_d;

  logic [5:0]            mapped;
  logic [GROUP_BITS-1:0] bits_new;
  logic [GROUP_BITS-1:0] aligned;
  logic                  inv_new;
  logic [2:0]            tail_count;
  logic                  tail_bad_len;

  assign mapped   = map_symbol(symbol_i);
  assign bits_new = {group_bits_q[GROUP_BITS-6:0], mapped[4:0] & {5{mapped[5]}}};
  assign inv_new  = invalid_q | ~mapped[5];

  always_comb begin
    aligned      = bits_new;
    tail_count   = 3'd0;
    tail_bad_len = 1'b0;
    unique case (held_q)
      3'd0: begin aligned = bits_new << 35; tail_bad_len = 1'b1; end
      3'd1: begin aligned = bits_new << 30; tail_count = 3'd1; end
      3'd2: begin aligned = bits_new << 25; tail_bad_len = 1'b1; end
      3'd3: begin aligned = bits_new << 20; tail_count = 3'd2; end
      3'd4: begin aligned = bits_new << 15; tail_count = 3'd3; end
      3'd5: begin aligned = bits_new << 10; tail_bad_len = 1'b1; end
      3'd6: begin aligned = bits_new << 5;  tail_count = 3'd4; end
      default: begin aligned = bits_new; tail_count = 3'd5; end
    endcase
  end

  always_comb begin
    group_bits_d  = group_bits_q;
    held_d        = held_q;
    invalid_d     = invalid_q;
    discard_d     = discard_q;
    job_valid_o   = 1'b0;
    job_o.bytes   = '0;
    job_o.count   = 3'd1;
    job_o.status  = STATUS_OK;
    job_o.msg_end = 1'b1;
    if (accept_i) begin
      if (discard_q) begin
        if (msg_end_i) begin
          discard_d    = 1'b0;
          group_bits_d = '0;
          held_d       = 3'd0;
          invalid_d    = 1'b0;
        end
      end else if (held_q == 3'd7 || msg_end_i) begin
        group_bits_d = '0;
        held_d       = 3'd0;
        invalid_d    = 1'b0;
        job_valid_o  = 1'b1;
        if (held_q != 3'd7 && tail_bad_len) begin
          job_o.status = STATUS_BAD_LEN;
        end else if (inv_new) begin
          job_o.status = STATUS_BAD_CHAR;
          discard_d    = ~msg_end_i;
        end else begin
          job_o.bytes   = aligned;
          job_o.count   = tail_count;
          job_o.msg_end = msg_end_i;
        end
      end else begin
        group_bits_d = bits_new;
        held_d       = held_q + 3'd1;
        invalid_d    = inv_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_bits_q <= '0;
      held_q       <= 3'd0;
      invalid_q    <= 1'b0;
      discard_q    <= 1'b0;
    end else begin
      group_bits_q <= group_bits_d;
      held_q       <= held_d;
      invalid_q    <= invalid_d;
      discard_q    <= discard_d;
    end
  end

endmodule

/* sv/b32dec_queue.sv */
module b32dec_queue import b32dec_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* sv/b32dec_back.sv */
module b32dec_back import b32dec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_status_o,
  output logic       out_group_done_o,
  output logic       out_stream_done_o
);

  job_t       job_q;
  logic [2:0] k_q, k_d;
  logic       busy_q, busy_d;
  logic       valid_q;
  logic [7:0] byte_q;
  logic [1:0] status_q;
  logic       gd_q, sd_q;

  logic       adv, emit, last;
  logic [7:0] sel_byte;

  assign adv       = !valid_q || out_ready_i;
  assign emit      = busy_q && adv;
  assign last      = (k_q + 3'd1 == job_q.count);
  assign job_pop_o = job_valid_i && (!busy_q || (emit && last));

  always_comb begin
    unique case (k_q)
      3'd0:    sel_byte = job_q.bytes[39:32];
      3'd1:    sel_byte = job_q.bytes[31:24];
      3'd2:    sel_byte = job_q.bytes[23:16];
      3'd3:    sel_byte = job_q.bytes[15:8];
      default: sel_byte = job_q.bytes[7:0];
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (job_pop_o) begin
      busy_d = 1'b1;
      k_d    = 3'd0;
    end else if (emit) begin
      k_d = k_q + 3'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      byte_q   <= sel_byte;
      status_q <= job_q.status;
      gd_q     <= last;
      sd_q     <= last && job_q.msg_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      k_q     <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (adv) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = valid_q;
  assign out_byte_o        = byte_q;
  assign out_status_o      = status_q;
  assign out_group_done_o  = gd_q;
  assign out_stream_done_o = sd_q;

endmodule

/* sv/base32_decoder_validating.sv */
// Results pass through the job queue, then the back end's job and output registers.
// Throughput: one symbol per cycle unless the queue is full; one byte per cycle if ready.
// A full group of eight symbols releases five bytes, so the output keeps pace.
// s_axis_tready drops only while the job queue between front and back is full.
// Reset: rst_ni is asynchronous, active low; it clears group state and empties the queue.
module base32_decoder_validating import b32dec_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [2:0] m_axis_tuser,   // [1:0] status, [2] group_done
  output logic       m_axis_tlast
);

  logic accept;
  logic job_valid, q_full, q_valid, q_pop;
  job_t front_job, q_job;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  b32dec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .symbol_i   (s_axis_tdata),
    .msg_end_i  (s_axis_tlast),
    .job_valid_o(job_valid),
    .job_o      (front_job)
  );

  b32dec_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .job_i  (front_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (q_job)
  );

  b32dec_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_valid),
    .job_i            (q_job),
    .job_pop_o        (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (m_axis_tdata),
    .out_status_o     (m_axis_tuser[1:0]),
    .out_group_done_o (m_axis_tuser[2]),
    .out_stream_done_o(m_axis_tlast)
  );

endmodule

/* sv/b32dec_checker.sv */
module b32dec_port_props import b32dec_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] != STATUS_OK |->
      m_axis_tdata == 8'd0 && m_axis_tuser[2] && m_axis_tlast)
    else $error("error result not a zero final transaction");

  a_last_closes_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2])
    else $error("message end without group end");

  a_mid_group_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |->
      m_axis_tuser[1:0] == STATUS_OK && !m_axis_tlast)
    else $error("inner byte of a group carries status or end");

endmodule

bind base32_decoder_validating b32dec_port_props u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

/* tb/b32dec_checker.sv */
`timescale 1ns / 1ps

module b32dec_checker import b32dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       group_done;
    logic       stream_done;
  } decoded_byte_t;

  decoded_byte_t decoded_q[$];

  logic [39:0] held_bits;
  logic [2:0]  held_count;
  logic        held_bad;
  logic        skipping;
  int unsigned mismatches;

  // Bit 5 marks a character of the alphabet, bits 4:0 carry its value.
  function automatic logic [5:0] char_value(logic [7:0] c);
    logic [7:0] up;
    up = c;
    if (c >= "a" && c <= "z") up = c - 8'd32;
    if (c >= "0" && c <= "9") return {1'b1, 5'(c - "0")};
    if (up >= "A" && up <= "H") return {1'b1, 5'(up - "A" + 8'd10)};
    case (up)
      "I", "L": return {1'b1, 5'd1};
      "O", "Q": return {1'b1, 5'd0};
      "J":      return {1'b1, 5'd18};
      "K":      return {1'b1, 5'd19};
      "M":      return {1'b1, 5'd20};
      "N":      return {1'b1, 5'd21};
      "P":      return {1'b1, 5'd22};
      "R":      return {1'b1, 5'd23};
      "S":      return {1'b1, 5'd24};
      "T":      return {1'b1, 5'd25};
      "U", "V": return {1'b1, 5'd26};
      "W":      return {1'b1, 5'd27};
      "X":      return {1'b1, 5'd28};
      "Y":      return {1'b1, 5'd29};
      "Z":      return {1'b1, 5'd30};
      "_":      return {1'b1, 5'd31};
      default:  return 6'd0;
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] data, logic [1:0] st, logic gd, logic sd);
    decoded_byte_t b;
    b.data_byte   = data;
    b.status      = st;
    b.group_done  = gd;
    b.stream_done = sd;
    decoded_q.push_back(b);
  endfunction

  function automatic void clear_group();
    held_bits  = '0;
    held_count = '0;
    held_bad   = 1'b0;
  endfunction

  function automatic void decode_symbol(logic [7:0] sym, logic last);
    logic [5:0]  mapped;
    logic [39:0] aligned;
    int unsigned n;
    int unsigned nbytes;
    if (skipping) begin
      if (last) begin
        skipping = 1'b0;
        clear_group();
      end
      return;
    end
    mapped = char_value(sym);
    if (!mapped[5]) held_bad = 1'b1;
    held_bits = {held_bits[34:0], (mapped[5] ? mapped[4:0] : 5'd0)};
    n = held_count + 1;
    if (n == 8) begin
      if (held_bad) begin
        push_byte(8'd0, STATUS_BAD_CHAR, 1'b1, 1'b1);
        if (!last) skipping = 1'b1;
      end else begin
        for (int k = 0; k < 5; k++) begin
          push_byte(held_bits[39-8*k -: 8], STATUS_OK, k == 4, last && k == 4);
        end
      end
      clear_group();
      return;
    end
    if (!last) begin
      held_count = 3'(n);
      return;
    end
    // Message tail: left-align the held symbols, drop spare low bits.
    aligned = held_bits << (5 * (8 - n));
    if (n == 1 || n == 3 || n == 6) begin
      push_byte(8'd0, STATUS_BAD_LEN, 1'b1, 1'b1);
    end else if (held_bad) begin
      push_byte(8'd0, STATUS_BAD_CHAR, 1'b1, 1'b1);
    end else begin
      nbytes = (n * 5) / 8;
      for (int k = 0; k < nbytes; k++) begin
        push_byte(aligned[39-8*k -: 8], STATUS_OK, k + 1 == nbytes, k + 1 == nbytes);
      end
    end
    clear_group();
  endfunction

  always @(posedge clk_i) begin
    decoded_byte_t want;
    logic          wrong;
    if (!rst_ni) begin
      decoded_q.delete();
      clear_group();
      skipping   = 1'b0;
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output transaction: data_byte %02h status %0d",
                 m_axis_tdata, m_axis_tuser[1:0]);
          mismatches++;
        end else begin
          want  = decoded_q.pop_front();
          wrong = 1'b0;
          if (m_axis_tdata !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte, m_axis_tdata);
            wrong = 1'b1;
          end
          if (m_axis_tuser[1:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser[1:0]);
            wrong = 1'b1;
          end
          if (m_axis_tuser[2] !== want.group_done) begin
            $error("group_done: expected %0b, actual %0b", want.group_done, m_axis_tuser[2]);
            wrong = 1'b1;
          end
          if (m_axis_tlast !== want.stream_done) begin
            $error("stream_done: expected %0b, actual %0b", want.stream_done, m_axis_tlast);
            wrong = 1'b1;
          end
          if (wrong) mismatches++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_symbol(s_axis_tdata, s_axis_tlast);
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= decoded_q.size();
  end

endmodule

/* tb/tb_base32_decoder_validating.sv */
`timescale 1ns / 1ps

module tb_base32_decoder_validating;

  localparam int unsigned RandomItems = 350;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned symbols_sent;

  base32_decoder_validating i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  b32dec_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("base32_decoder_validating regression: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_symbol(input logic [7:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    symbols_sent++;
  endtask

  task automatic send_text(input string text, input logic ends_message);
    for (int i = 0; i < text.len(); i++) begin
      send_symbol(text[i], ends_message && (i == text.len() - 1));
    end
  endtask

  // Hold off the sender until every decoded byte has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] alphabet_char();
    int unsigned r;
    r = $urandom_range(62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    return "_";
  endfunction

  function automatic logic [7:0] foreign_char();
    case ($urandom_range(5))
      0:       return 8'($urandom_range(128, 255));
      1:       return 8'($urandom_range(8'h00, 8'h2f));
      2:       return 8'($urandom_range(8'h3a, 8'h40));
      3:       return 8'($urandom_range(8'h5b, 8'h5e));
      4:       return 8'h60;
      default: return 8'($urandom_range(8'h7b, 8'h7f));
    endcase
  endfunction

  task automatic send_random_message();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  sym;
    logic        last;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 17);
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1);
      if (kind < 70) begin
        sym = alphabet_char();
      end else if (kind < 85) begin
        sym = ($urandom_range(len) == 0) ? foreign_char() : alphabet_char();
      end else begin
        sym  = 8'($urandom_range(255));
        last = last || ($urandom_range(7) == 0);
      end
      send_symbol(sym, last);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    symbols_sent  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two-symbol tail, then a one-symbol tail that is also a foreign byte
    send_text("Hi", 1'b1);
    send_symbol(8'h00, 1'b1);
    // five-symbol tail holding foreign bytes at the range edges
    send_symbol(8'h80, 1'b0);
    send_symbol("A", 1'b0);
    send_symbol(8'h7f, 1'b0);
    send_symbol("b", 1'b0);
    send_symbol(8'hff, 1'b1);
    // full group closing the message
    send_text("_uvQ7Jk9", 1'b1);
    // bad group mid-message, then drop until the end flag
    send_text("!AAAAAAA", 1'b0);
    send_text("xy", 1'b1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (symbols_sent < 25 + RandomItems * (phase + 1) / 3) send_random_message();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("base32_decoder_validating regression: pass");
    end else begin
      $display("base32_decoder_validating regression: fail");
    end
    $finish;
  end

endmodule
